### hdl/sas_pkg.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer package
// Item and result layouts, program entry layout, codes and sizes.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam int PROG_DEPTH = 16;
	localparam int PROG_AW    = $clog2(PROG_DEPTH);
	localparam int FRAME_W    = 8;
	localparam int DUR_W      = 24;
	localparam int TIMER_W    = 32;
	localparam int ELAPSED_W  = 16;
	localparam int SLOT_W     = 4;
	localparam int TGT_W      = 4;

	// item actions
	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_TICK    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// program entry kinds
	localparam logic [1:0] KIND_PLAY = 2'd0;
	localparam logic [1:0] KIND_LOOP = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_LOOP    = 2'd1;
	localparam logic [1:0] ERR_OFF_END = 2'd2;

	typedef struct packed {
		logic [1:0]           action;
		logic [SLOT_W-1:0]    entry_slot;
		logic [1:0]           entry_kind;
		logic [FRAME_W-1:0]   entry_frame;
		logic [DUR_W-1:0]     entry_duration;
		logic [TGT_W-1:0]     entry_loop_target;
		logic [ELAPSED_W-1:0] elapsed;
	} sas_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] display_frame;
		logic               animation_done;
		logic [1:0]         error_code;
	} sas_result_t;

	// a loop entry keeps its target in the low duration bits
	typedef struct packed {
		logic [1:0]         kind;
		logic [FRAME_W-1:0] frame;
		logic [DUR_W-1:0]   dur;
	} sas_entry_t;

	localparam int ENTRY_W = $bits(sas_entry_t);

endpackage

### hdl/sas_stream_if.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer stream interface
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface sas_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

### hdl/sas_ram.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/sprite_animation_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer
// Plays a stored program of play / loop / end entries, one result per item.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload        transfer when
//  -------   ---------  -------------  -------------------------
//  item      in         sas_item_t     item.valid & item.ready
//  result    out        sas_result_t   result.valid & result.ready
//
//  Write, restart and unused actions, ticks that finish no frame and those
//  past the last slot load their result as the item is taken. Other ticks
//  read the next entry, then a loop target, on the single RAM read port.
//  Results sit in an output register; a new item is taken while the last
//  result is being transferred. arst_n clears positions, timer, done flag
//  and the walk state; program entries are undefined until written.
//
module sprite_animation_sequencer_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	sas_stream_if.sink           item,
	sas_stream_if.source         result
);

	import sas_pkg::*;

	// walk state for ticks that advance the program
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NEXT = 2'd1;   // next entry being read
	localparam logic [1:0] ST_TGT  = 2'd2;   // loop target being read

	logic [1:0]         state_q, state_d;
	logic [PROG_AW-1:0] seq_q, seq_d;        // sequence position
	logic [PROG_AW-1:0] cur_q, cur_d;        // current play position
	logic [PROG_AW-1:0] tgt_q, tgt_d;        // pending loop target
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic               done_q, done_d;

	// copies of the current entry and of entry 0 (restart target)
	logic [FRAME_W-1:0] cf_q, cf_d;
	logic [DUR_W-1:0]   cd_q, cd_d;
	logic [FRAME_W-1:0] e0f_q, e0f_d;
	logic [DUR_W-1:0]   e0d_q, e0d_d;

	logic               out_valid_q, out_valid_d;
	sas_result_t        out_data_q, out_data_d;

	// RAM ports
	logic               ram_we, ram_re;
	logic [PROG_AW-1:0] ram_waddr, ram_raddr;
	sas_entry_t         wr_entry, rd_entry;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               in_xfer;
	logic               ld_out, do_restart;
	logic [1:0]         err;
	logic [PROG_AW:0]   next_ext;
	logic [TIMER_W:0]   tsum;
	logic [TIMER_W-1:0] tsat;
	logic               slot_ok;

	sas_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PROG_DEPTH)
	) u_prog (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = sas_entry_t'(ram_rdata);

	// take an item only between walks and with the output slot free or draining
	assign item.ready   = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign in_xfer      = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// saturating timer add, next sequence position
	assign tsum     = {1'b0, timer_q} + (TIMER_W+1)'(item.data.elapsed);
	assign tsat     = tsum[TIMER_W] ? {TIMER_W{1'b1}} : tsum[TIMER_W-1:0];
	assign next_ext = {1'b0, seq_q} + (PROG_AW+1)'(1);
	assign slot_ok  = 32'(item.data.entry_slot) < 32'(PROG_DEPTH);

	// entry image for a write item
	always_comb begin
		wr_entry.kind  = item.data.entry_kind;
		wr_entry.frame = '0;
		wr_entry.dur   = '0;
		if (item.data.entry_kind == KIND_PLAY) begin
			wr_entry.frame = item.data.entry_frame;
			wr_entry.dur   = item.data.entry_duration;
		end else if (item.data.entry_kind == KIND_LOOP) begin
			wr_entry.dur = DUR_W'(item.data.entry_loop_target);
		end
	end

	always_comb begin
		state_d    = state_q;
		seq_d      = seq_q;
		cur_d      = cur_q;
		tgt_d      = tgt_q;
		timer_d    = timer_q;
		done_d     = done_q;
		cf_d       = cf_q;
		cd_d       = cd_q;
		e0f_d      = e0f_q;
		e0d_d      = e0d_q;
		ram_we     = 1'b0;
		ram_waddr  = PROG_AW'(item.data.entry_slot);
		ram_re     = 1'b0;
		ram_raddr  = next_ext[PROG_AW-1:0];
		ld_out     = 1'b0;
		do_restart = 1'b0;
		err        = ERR_NONE;

		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					ld_out = 1'b1;
					case (item.data.action)
						ACT_WRITE: begin
							if (slot_ok) begin
								ram_we = 1'b1;
								// keep register copies coherent with the store
								if (ram_waddr == cur_q) begin
									cf_d = wr_entry.frame;
									cd_d = (wr_entry.kind == KIND_PLAY) ? wr_entry.dur : '0;
								end
								if (ram_waddr == '0) begin
									e0f_d = wr_entry.frame;
									e0d_d = (wr_entry.kind == KIND_PLAY) ? wr_entry.dur : '0;
								end
							end
						end
						ACT_TICK: begin
							if (!done_q) begin
								timer_d = tsat;
								if (tsat >= TIMER_W'(cd_q)) begin
									timer_d = '0;
									if (next_ext >= (PROG_AW+1)'(PROG_DEPTH)) begin
										done_d = 1'b1;
										err    = ERR_OFF_END;
									end else begin
										// fetch the next entry, result comes later
										ram_re  = 1'b1;
										state_d = ST_NEXT;
										ld_out  = 1'b0;
									end
								end
							end
						end
						ACT_RESTART: do_restart = 1'b1;
						default: ;
					endcase
				end
			end
			ST_NEXT: begin
				ld_out  = 1'b1;
				state_d = ST_IDLE;
				case (rd_entry.kind)
					KIND_PLAY: begin
						seq_d = next_ext[PROG_AW-1:0];
						cur_d = next_ext[PROG_AW-1:0];
						cf_d  = rd_entry.frame;
						cd_d  = rd_entry.dur;
					end
					KIND_END: begin
						seq_d  = next_ext[PROG_AW-1:0];
						done_d = 1'b1;
					end
					KIND_LOOP: begin
						if (32'(rd_entry.dur[TGT_W-1:0]) < 32'(PROG_DEPTH)) begin
							tgt_d     = PROG_AW'(rd_entry.dur[TGT_W-1:0]);
							ram_re    = 1'b1;
							ram_raddr = PROG_AW'(rd_entry.dur[TGT_W-1:0]);
							state_d   = ST_TGT;
							ld_out    = 1'b0;
						end else begin
							do_restart = 1'b1;
							err        = ERR_LOOP;
						end
					end
					default: begin
						// unknown entry kind: stop where we are
						done_d = 1'b1;
						err    = ERR_OFF_END;
					end
				endcase
			end
			ST_TGT: begin
				ld_out  = 1'b1;
				state_d = ST_IDLE;
				if (rd_entry.kind == KIND_PLAY) begin
					seq_d = tgt_q;
					cur_d = tgt_q;
					cf_d  = rd_entry.frame;
					cd_d  = rd_entry.dur;
				end else begin
					do_restart = 1'b1;
					err        = ERR_LOOP;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (do_restart) begin
			seq_d   = '0;
			cur_d   = '0;
			timer_d = '0;
			done_d  = 1'b0;
			cf_d    = e0f_q;
			cd_d    = e0d_q;
		end

		// result register
		out_valid_d = out_valid_q;
		out_data_d  = out_data_q;
		if (ld_out) begin
			out_valid_d               = 1'b1;
			out_data_d.display_frame  = cf_d;
			out_data_d.animation_done = done_d;
			out_data_d.error_code     = err;
		end else if (result.ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seq_q       <= '0;
			cur_q       <= '0;
			timer_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			seq_q       <= seq_d;
			cur_q       <= cur_d;
			timer_q     <= timer_d;
			done_q      <= done_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tgt_q      <= tgt_d;
		cf_q       <= cf_d;
		cd_q       <= cd_d;
		e0f_q      <= e0f_d;
		e0d_q      <= e0d_d;
		out_data_q <= out_data_d;
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !item.ready)
		else $error("item taken during a program walk");

	a_walk_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result slot occupied during a program walk");

	a_loop_err_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.error_code == ERR_LOOP) |-> !out_data_q.animation_done)
		else $error("loop error without restart");

	a_off_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.error_code == ERR_OFF_END) |-> out_data_q.animation_done)
		else $error("run-off-end error without done");

endmodule
